// File: rtl/i2c_master_byte_engine_macros.svh
// Assertion macros shared by the I2C master byte engine RTL.
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH

// Same-cycle implication on the module clock, off during reset.
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on the module clock, off during reset.
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/i2cm_pkg.sv
// Types and constants for the I2C master byte engine.
package i2cm_pkg;

  localparam int HP_W = 16;
  localparam int TIMER_BITS_DEF = 16;
  localparam logic [HP_W-1:0] HALF_PERIOD_RESET = 16'd500;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_S_A    = 4'd1,
    PH_S_B    = 4'd2,
    PH_S_C    = 4'd3,
    PH_P_A    = 4'd4,
    PH_P_B    = 4'd5,
    PH_P_C    = 4'd6,
    PH_BIT_LO = 4'd7,
    PH_BIT_HI = 4'd8,
    PH_ACK_LO = 4'd9,
    PH_ACK_HI = 4'd10
  } phase_t;

  typedef struct packed {
    logic       cmd_valid;
    cmd_t       command;
    logic [7:0] tx_byte;
    logic       send_nack;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       slave_nack;
  } result_t;

endpackage

// File: rtl/i2cm_core.sv
// Bus sequencer: phase state, bit shifter and phase timer, one tick per item.
`include "i2c_master_byte_engine_macros.svh"

module i2cm_core #(
  parameter int TIMER_BITS = i2cm_pkg::TIMER_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  i2cm_pkg::item_t            item,
  input  logic [i2cm_pkg::HP_W-1:0]  half_period,
  output i2cm_pkg::result_t          res
);

  localparam int WIDE = (TIMER_BITS > i2cm_pkg::HP_W) ? TIMER_BITS : i2cm_pkg::HP_W;
  localparam logic [WIDE-1:0] TIMER_MAX_W = WIDE'({TIMER_BITS{1'b1}});

  i2cm_pkg::phase_t phase, phase_next;
  i2cm_pkg::cmd_t   active_command, active_command_next;
  logic [3:0]            bit_count, bit_count_next;
  logic [7:0]            shift_reg, shift_reg_next;
  logic [TIMER_BITS-1:0] phase_timer, phase_timer_next;
  logic                  nack_choice, nack_choice_next;
  logic                  ack_seen, ack_seen_next;
  logic                  scl_reg, scl_reg_next;
  logic                  sda_reg, sda_reg_next;
  logic [7:0]            rx_last, rx_last_next;
  logic                  done;

  logic [i2cm_pkg::HP_W-1:0] hp_eff;
  logic [i2cm_pkg::HP_W-1:0] hp_m1;
  logic [WIDE-1:0]           hp_wide;
  logic [TIMER_BITS-1:0]     timer_load;
  logic                      is_idle;
  logic                      start;
  logic                      adv;
  logic                      is_read;
  logic [3:0]                bit_count_inc;
  logic [7:0]                shift_upd;

  always_comb begin
    hp_eff     = (half_period == '0) ? i2cm_pkg::HP_W'(1) : half_period;
    hp_m1      = hp_eff - i2cm_pkg::HP_W'(1);
    hp_wide    = WIDE'(hp_m1);
    timer_load = (hp_wide > TIMER_MAX_W) ? TIMER_BITS'(TIMER_MAX_W) : TIMER_BITS'(hp_wide);
  end

  assign is_idle       = (phase == i2cm_pkg::PH_IDLE);
  assign start         = step && is_idle && item.cmd_valid;
  assign adv           = step && !is_idle && (phase_timer == '0);
  assign is_read       = (active_command == i2cm_pkg::CMD_READ);
  assign bit_count_inc = bit_count + 4'd1;

  always_comb begin
    shift_upd = shift_reg;
    if (is_read) begin
      shift_upd[~bit_count[2:0]] = item.sda_sample;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (start) begin
      unique case (item.command)
        i2cm_pkg::CMD_START: phase_next = i2cm_pkg::PH_S_A;
        i2cm_pkg::CMD_STOP:  phase_next = i2cm_pkg::PH_P_A;
        i2cm_pkg::CMD_WRITE: phase_next = i2cm_pkg::PH_BIT_LO;
        i2cm_pkg::CMD_READ:  phase_next = i2cm_pkg::PH_BIT_LO;
        default:             phase_next = i2cm_pkg::PH_IDLE;
      endcase
    end else if (adv) begin
      unique case (phase)
        i2cm_pkg::PH_S_A:    phase_next = i2cm_pkg::PH_S_B;
        i2cm_pkg::PH_S_B:    phase_next = i2cm_pkg::PH_S_C;
        i2cm_pkg::PH_P_A:    phase_next = i2cm_pkg::PH_P_B;
        i2cm_pkg::PH_P_B:    phase_next = i2cm_pkg::PH_P_C;
        i2cm_pkg::PH_BIT_LO: phase_next = i2cm_pkg::PH_BIT_HI;
        i2cm_pkg::PH_BIT_HI: begin
          phase_next = (bit_count_inc < 4'd8) ? i2cm_pkg::PH_BIT_LO : i2cm_pkg::PH_ACK_LO;
        end
        i2cm_pkg::PH_ACK_LO: phase_next = i2cm_pkg::PH_ACK_HI;
        default:             phase_next = i2cm_pkg::PH_IDLE;
      endcase
    end
  end

  // line levels, datapath and done
  always_comb begin
    active_command_next = active_command;
    bit_count_next      = bit_count;
    shift_reg_next      = shift_reg;
    phase_timer_next    = phase_timer;
    nack_choice_next    = nack_choice;
    ack_seen_next       = ack_seen;
    scl_reg_next        = scl_reg;
    sda_reg_next        = sda_reg;
    rx_last_next        = rx_last;
    done                = 1'b0;
    if (start) begin
      active_command_next = item.command;
      scl_reg_next        = 1'b0;
      bit_count_next      = 4'd0;
      phase_timer_next    = timer_load;
      unique case (item.command)
        i2cm_pkg::CMD_WRITE: begin
          shift_reg_next = item.tx_byte;
          sda_reg_next   = item.tx_byte[7];
        end
        i2cm_pkg::CMD_READ: begin
          nack_choice_next = item.send_nack;
          shift_reg_next   = 8'd0;
          sda_reg_next     = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (step && !is_idle && (phase_timer != '0)) begin
      phase_timer_next = phase_timer - TIMER_BITS'(1);
    end else if (adv) begin
      phase_timer_next = timer_load;
      unique case (phase)
        i2cm_pkg::PH_S_A: begin
          scl_reg_next = 1'b1;
          sda_reg_next = 1'b1;
        end
        i2cm_pkg::PH_S_B: sda_reg_next = 1'b0;
        i2cm_pkg::PH_S_C: begin
          scl_reg_next = 1'b0;
          done         = 1'b1;
        end
        i2cm_pkg::PH_P_A: begin
          sda_reg_next = 1'b0;
          scl_reg_next = 1'b1;
        end
        i2cm_pkg::PH_P_B: sda_reg_next = 1'b1;
        i2cm_pkg::PH_P_C: done = 1'b1;
        i2cm_pkg::PH_BIT_LO: scl_reg_next = 1'b1;
        i2cm_pkg::PH_BIT_HI: begin
          shift_reg_next = shift_upd;
          bit_count_next = bit_count_inc;
          scl_reg_next   = 1'b0;
          if (bit_count_inc < 4'd8) begin
            sda_reg_next = is_read ? 1'b1 : shift_upd[~bit_count_inc[2:0]];
          end else begin
            sda_reg_next = is_read ? nack_choice : 1'b1;
          end
        end
        i2cm_pkg::PH_ACK_LO: scl_reg_next = 1'b1;
        i2cm_pkg::PH_ACK_HI: begin
          if (is_read) begin
            rx_last_next = shift_reg;
          end else begin
            ack_seen_next = item.sda_sample;
          end
          sda_reg_next = 1'b1;
          done         = 1'b1;
        end
        default: begin
          scl_reg_next = 1'b1;
          sda_reg_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= i2cm_pkg::PH_IDLE;
      active_command <= i2cm_pkg::CMD_START;
      bit_count      <= 4'd0;
      shift_reg      <= 8'd0;
      phase_timer    <= '0;
      nack_choice    <= 1'b0;
      ack_seen       <= 1'b0;
      scl_reg        <= 1'b1;
      sda_reg        <= 1'b1;
      rx_last        <= 8'd0;
    end else if (step) begin
      phase          <= phase_next;
      active_command <= active_command_next;
      bit_count      <= bit_count_next;
      shift_reg      <= shift_reg_next;
      phase_timer    <= phase_timer_next;
      nack_choice    <= nack_choice_next;
      ack_seen       <= ack_seen_next;
      scl_reg        <= scl_reg_next;
      sda_reg        <= sda_reg_next;
      rx_last        <= rx_last_next;
    end
  end

  always_comb begin
    res.scl_level  = scl_reg_next;
    res.sda_level  = sda_reg_next;
    res.ready_res  = is_idle;
    res.done_res   = done;
    res.rx_byte    = rx_last_next;
    res.slave_nack = ack_seen_next;
  end

  `I2CM_ASSERT_NEXT(a_start_leaves_idle, start, phase != i2cm_pkg::PH_IDLE,
                    "accepted command left the engine idle")
  `I2CM_ASSERT_NOW(a_bit_count_range,
                   (phase == i2cm_pkg::PH_BIT_LO) || (phase == i2cm_pkg::PH_BIT_HI),
                   bit_count < 4'd8, "bit counter past the last data bit")

endmodule

// File: rtl/i2c_master_byte_engine.sv
// Top level of the I2C master byte engine: handshakes, config register, result register.
//
// Usage: each input item on in_valid/in_ready is one tick of the bus sequencer,
// carrying an optional command (start, stop, write byte, read byte), the byte to
// send, the ack/nack choice for reads and the sampled SDA level. Every accepted
// item yields exactly one result item on out_valid/out_ready with the open-drain
// SCL/SDA drive levels, the ready and done flags, the last read byte and the
// slave acknowledge of the last write.
// The result register presents a result in the cycle after its item is accepted.
// Throughput: one item per cycle while out_ready is high; the result register is the
// only stage, and a new item is taken in the cycle the pending result is taken.
// Each bus phase lasts half_period items (zero counts as one), written through
// cfg_valid/cfg_ready/cfg_data, which is always ready.
// Reset: synchronous rst returns the sequencer to idle with both lines released,
// half_period to 500 and empties the result register.
// Stall: while a result waits with out_ready low, in_ready is low and the
// sequencer holds its state.
`include "i2c_master_byte_engine_macros.svh"

module i2c_master_byte_engine #(
  parameter int TIMER_BITS = i2cm_pkg::TIMER_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  i2cm_pkg::item_t            in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output i2cm_pkg::result_t          out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [i2cm_pkg::HP_W-1:0]  cfg_data
);

  logic [i2cm_pkg::HP_W-1:0] half_period;
  logic                      in_accept;
  i2cm_pkg::result_t         res;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= i2cm_pkg::HALF_PERIOD_RESET;
    end else if (cfg_valid) begin
      half_period <= cfg_data;
    end
  end

  i2cm_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (in_accept),
    .item        (in_data),
    .half_period (half_period),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= res;
    end
  end

  `I2CM_ASSERT_NOW(a_stall_blocks_input, out_valid && !out_ready, !in_ready,
                   "item taken while a result waits")
  `I2CM_ASSERT_NOW(a_done_not_ready, in_accept, !(res.done_res && res.ready_res),
                   "completion reported while idle")

endmodule
